[sv/pbmc_pkg.sv]
// shared constants, types and functions of the packed base mismatch counter
package pbmc_pkg;

  localparam int CHUNK_BYTES   = 32;
  localparam int MAX_CHUNKS    = 1024;
  localparam int WORD_W        = 64;
  localparam int WORD_BYTES    = WORD_W / 8;
  localparam int VALID_W       = 6;
  localparam int SUM_W         = 13;
  localparam int TOT_W         = 3;
  localparam int LANE_CNT_W    = 3;
  localparam int PAIRS_PER_BYTE = 4;
  localparam logic [TOT_W-1:0] STOP_LIMIT = TOT_W'(2);

  // stopped count of a run of bytes, starting from a prefix of zero or one
  typedef struct packed {
    logic [TOT_W-1:0] from0;
    logic [TOT_W-1:0] from1;
  } pbmc_span_t;

  function automatic logic [TOT_W-1:0] pbmc_follow(
    input logic [TOT_W-1:0] v,
    input pbmc_span_t       r
  );
    logic [TOT_W-1:0] res;
    if (v >= STOP_LIMIT) begin
      res = v;
    end else if (v[0]) begin
      res = r.from1;
    end else begin
      res = r.from0;
    end
    return res;
  endfunction

  function automatic pbmc_span_t pbmc_join(input pbmc_span_t l, input pbmc_span_t r);
    pbmc_span_t res;
    res.from0 = pbmc_follow(l.from0, r);
    res.from1 = pbmc_follow(l.from1, r);
    return res;
  endfunction

endpackage

[sv/pbmc_ifs.sv]
// word channels of the packed base mismatch counter

interface pbmc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pbmc_pkg::WORD_W-1:0]   first_a_word0;
  logic [pbmc_pkg::WORD_W-1:0]   first_a_word1;
  logic [pbmc_pkg::WORD_W-1:0]   first_a_word2;
  logic [pbmc_pkg::WORD_W-1:0]   first_a_word3;
  logic [pbmc_pkg::WORD_W-1:0]   second_b_word0;
  logic [pbmc_pkg::WORD_W-1:0]   second_b_word1;
  logic [pbmc_pkg::WORD_W-1:0]   second_b_word2;
  logic [pbmc_pkg::WORD_W-1:0]   second_b_word3;
  logic [pbmc_pkg::VALID_W-1:0]  valid_bytes;
  logic                          last_chunk;

  modport source (
    output valid, first_a_word0, first_a_word1, first_a_word2, first_a_word3,
           second_b_word0, second_b_word1, second_b_word2, second_b_word3,
           valid_bytes, last_chunk,
    input  ready
  );
  modport sink (
    input  valid, first_a_word0, first_a_word1, first_a_word2, first_a_word3,
           second_b_word0, second_b_word1, second_b_word2, second_b_word3,
           valid_bytes, last_chunk,
    output ready
  );
endinterface

interface pbmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pbmc_pkg::SUM_W-1:0]  total_mismatch;
  logic                        is_duplicate;

  modport source (output valid, total_mismatch, is_duplicate, input ready);
  modport sink (input valid, total_mismatch, is_duplicate, output ready);
endinterface

[sv/pbmc_lane.sv]
// one byte lane: xor, nonzero base count and span summary
module pbmc_lane (
  input  logic [7:0]           a_byte_i,
  input  logic [7:0]           b_byte_i,
  input  logic                 en_i,
  output pbmc_pkg::pbmc_span_t span_o
);

  logic [7:0]                          diff;
  logic [pbmc_pkg::LANE_CNT_W-1:0]     cnt;

  assign diff = a_byte_i ^ b_byte_i;

  always_comb begin
    cnt = '0;
    for (int f = 0; f < pbmc_pkg::PAIRS_PER_BYTE; f++) begin
      if (diff[2*f +: 2] != 2'b00) begin
        cnt = cnt + pbmc_pkg::LANE_CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (en_i) begin
      span_o.from0 = pbmc_pkg::TOT_W'(cnt);
      span_o.from1 = pbmc_pkg::TOT_W'(cnt) + pbmc_pkg::TOT_W'(1);
    end else begin
      span_o.from0 = pbmc_pkg::TOT_W'(0);
      span_o.from1 = pbmc_pkg::TOT_W'(1);
    end
  end

endmodule

[sv/pbmc_merge.sv]
// in-order merge tree of lane summaries into the stopped chunk total
module pbmc_merge (
  input  pbmc_pkg::pbmc_span_t          lanes_i [pbmc_pkg::CHUNK_BYTES],
  output logic [pbmc_pkg::TOT_W-1:0]    total_o
);

  localparam int Nodes = 2 * pbmc_pkg::CHUNK_BYTES;

  // heap order: node 1 is the root, leaves sit at CHUNK_BYTES and up
  pbmc_pkg::pbmc_span_t tree [1:Nodes-1];

  for (genvar i = 0; i < pbmc_pkg::CHUNK_BYTES; i++) begin : g_leaf
    assign tree[pbmc_pkg::CHUNK_BYTES + i] = lanes_i[i];
  end

  for (genvar n = 1; n < pbmc_pkg::CHUNK_BYTES; n++) begin : g_node
    assign tree[n] = pbmc_pkg::pbmc_join(tree[2*n], tree[2*n+1]);
  end

  assign total_o = tree[1].from0;

endmodule

[sv/pbmc_accum.sv]
// saturating running sum and result word register
module pbmc_accum #(
  parameter int MaxChunks = pbmc_pkg::MAX_CHUNKS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [pbmc_pkg::TOT_W-1:0]    in_total_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pbmc_pkg::SUM_W-1:0]    out_total_o,
  output logic                          out_dup_o
);

  localparam int SumMax = 5 * MaxChunks;

  logic [pbmc_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [pbmc_pkg::SUM_W:0]   raw;
  logic [pbmc_pkg::SUM_W-1:0] sat;
  logic                       go;
  logic                       out_v_q, out_v_d;
  logic [pbmc_pkg::SUM_W-1:0] out_tot_q;
  logic                       out_dup_q;

  assign in_ready_o = !in_last_i || !out_v_q || out_ready_i;
  assign go         = in_valid_i && in_ready_o;

  assign raw = {1'b0, sum_q} + (pbmc_pkg::SUM_W + 1)'(in_total_i);
  assign sat = (raw > (pbmc_pkg::SUM_W + 1)'(SumMax)) ? pbmc_pkg::SUM_W'(SumMax)
                                                      : raw[pbmc_pkg::SUM_W-1:0];

  always_comb begin
    sum_d   = sum_q;
    out_v_d = out_v_q && !out_ready_i;
    if (go) begin
      if (in_last_i) begin
        sum_d   = '0;
        out_v_d = 1'b1;
      end else begin
        sum_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && in_last_i) begin
      out_tot_q <= sat;
      out_dup_q <= (sat < pbmc_pkg::SUM_W'(pbmc_pkg::STOP_LIMIT));
    end
  end

  assign out_valid_o = out_v_q;
  assign out_total_o = out_tot_q;
  assign out_dup_o   = out_dup_q;

endmodule

[sv/packed_base_mismatch_counter.sv]
// top level of the packed base mismatch counter
// Takes one 32-byte chunk pair per cycle. Thirty-two byte lanes and an in-order
// merge tree find the stopped chunk total in the cycle the word is accepted; it
// is registered, then added to the saturating running sum. A last chunk's result
// word is held in the result register after the stage register. The input stalls
// only when a last chunk waits behind a result word that has not been taken; other
// chunks keep flowing into the sum meanwhile.
module packed_base_mismatch_counter #(
  parameter int MaxChunks = pbmc_pkg::MAX_CHUNKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbmc_in_if.sink     in_i,
  pbmc_out_if.source  out_o
);

  localparam int Words = pbmc_pkg::CHUNK_BYTES / pbmc_pkg::WORD_BYTES;

  logic [pbmc_pkg::WORD_W-1:0]   a_words [Words];
  logic [pbmc_pkg::WORD_W-1:0]   b_words [Words];
  pbmc_pkg::pbmc_span_t          spans   [pbmc_pkg::CHUNK_BYTES];
  logic [pbmc_pkg::TOT_W-1:0]    total;

  logic                          s1_v_q;
  logic [pbmc_pkg::TOT_W-1:0]    s1_total_q;
  logic                          s1_last_q;
  logic                          s1_ready;
  logic                          s1_load;

  assign a_words[0] = in_i.first_a_word0;
  assign a_words[1] = in_i.first_a_word1;
  assign a_words[2] = in_i.first_a_word2;
  assign a_words[3] = in_i.first_a_word3;
  assign b_words[0] = in_i.second_b_word0;
  assign b_words[1] = in_i.second_b_word1;
  assign b_words[2] = in_i.second_b_word2;
  assign b_words[3] = in_i.second_b_word3;

  for (genvar i = 0; i < pbmc_pkg::CHUNK_BYTES; i++) begin : g_lane
    pbmc_lane u_lane (
      .a_byte_i (a_words[i / pbmc_pkg::WORD_BYTES][8*(i % pbmc_pkg::WORD_BYTES) +: 8]),
      .b_byte_i (b_words[i / pbmc_pkg::WORD_BYTES][8*(i % pbmc_pkg::WORD_BYTES) +: 8]),
      .en_i     (pbmc_pkg::VALID_W'(i) < in_i.valid_bytes),
      .span_o   (spans[i])
    );
  end

  pbmc_merge u_merge (
    .lanes_i (spans),
    .total_o (total)
  );

  assign in_i.ready = !s1_v_q || s1_ready;
  assign s1_load    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_total_q <= total;
      s1_last_q  <= in_i.last_chunk;
    end
  end

  pbmc_accum #(
    .MaxChunks (MaxChunks)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_v_q),
    .in_total_i  (s1_total_q),
    .in_last_i   (s1_last_q),
    .in_ready_o  (s1_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_total_o (out_o.total_mismatch),
    .out_dup_o   (out_o.is_duplicate)
  );

endmodule
